// ===== sv/cda_pkg.sv =====
// Shared definitions for the calendar date adder: operation codes, controller
// states, command and status words between controller and datapath, and the
// month length function. No dependencies.
package cda_pkg;

    // Operation codes carried on the op field
    localparam logic [2:0] OP_ADD_DAYS    = 3'd0;
    localparam logic [2:0] OP_ADD_WEEKS   = 3'd1;
    localparam logic [2:0] OP_ADD_MONTHS  = 3'd2;
    localparam logic [2:0] OP_ADD_YEARS   = 3'd3;
    localparam logic [2:0] OP_ADD_DECADES = 3'd4;

    // Widths of the working registers
    localparam int unsigned REM_W     = 19;  // up to 65535 weeks in days
    localparam int unsigned SCRATCH_W = 13;  // quotient by 12 or by 100
    localparam int unsigned YSUM_W    = 20;  // year plus ten times the count

    // Reciprocal constants: floor(x * MUL / 2**SHIFT) equals floor(x / N)
    // over the range of x used here, except that the quotient by 100 can read
    // one high for a year ending in 99; such a year is odd and never leap
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int unsigned DIV100_SHIFT = 19;
    localparam logic [16:0] DIV12_MUL    = 17'd87382;
    localparam int unsigned DIV12_SHIFT  = 20;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LDIV,
        ST_LSET,
        ST_CHECK,
        ST_WALK,
        ST_WDIV,
        ST_WSET,
        ST_MDIV,
        ST_MSET,
        ST_CDIV,
        ST_CSET,
        ST_CLAMP,
        ST_OUT
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;       // latch a new input word
        logic leap_div;   // quotient of year by 100
        logic leap_set;   // leap flag of the current year
        logic check;      // record the validity verdict
        logic walk;       // advance one month of the day walk
        logic mon_div;    // quotient of month total by 12
        logic mon_set;    // apply month, year or decade addition
        logic clamp;      // settle the day on anchor or month length
        logic finish;     // move the result to the output register
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic date_ok;    // start date and operation are valid
        logic op_walk;    // day or week operation
        logic op_month;   // month operation
        logic walk_last;  // remaining days fit in the current month
        logic walk_wrap;  // this walk step crosses into a new year
        logic out_free;   // output register may take a word this cycle
    } status_t;

    // Days in a month; months outside 1..12 read as 31
    function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        case (mon) inside
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            4'd2:                    len = leap ? 5'd29 : 5'd28;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== sv/cda_datapath.sv =====
// Datapath of the calendar date adder: working date registers, day walk,
// month and year arithmetic, leap test and the output register.
// Depends on cda_pkg.
module cda_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  cda_pkg::cmd_t       cmd,
    output cda_pkg::status_t    status,
    input  logic [2:0]          op,
    input  logic [4:0]          start_day,
    input  logic [3:0]          start_month,
    input  logic [15:0]         start_year,
    input  logic [15:0]         step_count,
    input  logic [4:0]          anchor_day,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [4:0]          end_day,
    output logic [3:0]          end_month,
    output logic [15:0]         end_year,
    output logic                year_overflow,
    output logic                bad_input
);

    // Working registers
    logic [2:0]                     op_reg, op_next;
    logic [4:0]                     day_reg, day_next;
    logic [3:0]                     mon_reg, mon_next;
    logic [15:0]                    year_reg, year_next;
    logic [cda_pkg::REM_W-1:0]      rem_reg, rem_next;
    logic [4:0]                     anchor_reg, anchor_next;
    logic                           ovf_reg, ovf_next;
    logic                           bad_reg, bad_next;
    logic [cda_pkg::SCRATCH_W-1:0]  quot_reg, quot_next;
    logic                           leap_reg, leap_next;

    // Output register
    logic                           out_valid_reg, out_valid_next;
    logic [4:0]                     end_day_reg, end_day_next;
    logic [3:0]                     end_month_reg, end_month_next;
    logic [15:0]                    end_year_reg, end_year_next;
    logic                           end_ovf_reg, end_ovf_next;
    logic                           end_bad_reg, end_bad_next;

    // Combinational helpers
    logic [4:0]                     cur_len;
    logic [4:0]                     left;
    logic                           fits;
    logic                           date_ok;
    logic [28:0]                    prod100;
    logic [15:0]                    rem100;
    logic [16:0]                    mtotal;
    logic [33:0]                    prod12;
    logic [16:0]                    times12;
    logic [16:0]                    rem12;
    logic [cda_pkg::YSUM_W-1:0]     ysum;
    logic [cda_pkg::REM_W-1:0]      count7;

    assign cur_len = cda_pkg::month_days(mon_reg, leap_reg);
    assign left    = cur_len - day_reg;
    assign fits    = rem_reg <= {{(cda_pkg::REM_W-5){1'b0}}, left};

    assign date_ok = (mon_reg >= 4'd1) && (mon_reg <= 4'd12) && (day_reg != 5'd0)
                   && (day_reg <= cur_len) && (op_reg <= cda_pkg::OP_ADD_DECADES);

    // Year split by 100 for the century rules
    assign prod100 = {13'd0, year_reg} * {16'd0, cda_pkg::DIV100_MUL};
    assign rem100  = year_reg - ({6'd0, quot_reg[9:0]} * 16'd100);

    // Month total split by 12
    assign mtotal  = {13'd0, mon_reg - 4'd1} + {1'b0, rem_reg[15:0]};
    assign prod12  = {17'd0, mtotal} * {17'd0, cda_pkg::DIV12_MUL};
    assign times12 = {1'b0, quot_reg, 3'd0} + {2'b0, quot_reg, 2'd0};
    assign rem12   = mtotal - times12;

    // Seven times the count, for weeks
    assign count7  = {step_count, 3'd0} - {3'd0, step_count};

    // Year sum for month, year and decade additions
    always_comb
    begin
        case (op_reg)
            cda_pkg::OP_ADD_MONTHS:
                ysum = {4'd0, year_reg} + {7'd0, quot_reg};
            cda_pkg::OP_ADD_YEARS:
                ysum = {4'd0, year_reg} + {4'd0, rem_reg[15:0]};
            default:
                ysum = {4'd0, year_reg} + {1'b0, rem_reg[15:0], 3'd0}
                     + {3'd0, rem_reg[15:0], 1'b0};
        endcase
    end

    // Status towards the controller
    always_comb
    begin
        status.date_ok   = date_ok;
        status.op_walk   = op_reg <= cda_pkg::OP_ADD_WEEKS;
        status.op_month  = op_reg == cda_pkg::OP_ADD_MONTHS;
        status.walk_last = fits;
        status.walk_wrap = !fits && (mon_reg == 4'd12);
        status.out_free  = !out_valid_reg || out_ready;
    end

    // Next state of the working and output registers
    always_comb
    begin
        op_next        = op_reg;
        day_next       = day_reg;
        mon_next       = mon_reg;
        year_next      = year_reg;
        rem_next       = rem_reg;
        anchor_next    = anchor_reg;
        ovf_next       = ovf_reg;
        bad_next       = bad_reg;
        quot_next      = quot_reg;
        leap_next      = leap_reg;
        out_valid_next = out_valid_reg;
        end_day_next   = end_day_reg;
        end_month_next = end_month_reg;
        end_year_next  = end_year_reg;
        end_ovf_next   = end_ovf_reg;
        end_bad_next   = end_bad_reg;

        // Drop a word the consumer has taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.load)
        begin
            op_next     = op;
            day_next    = start_day;
            mon_next    = start_month;
            year_next   = start_year;
            rem_next    = (op == cda_pkg::OP_ADD_WEEKS) ? count7 : {3'd0, step_count};
            anchor_next = (anchor_day == 5'd0) ? 5'd1 : anchor_day;
            ovf_next    = 1'b0;
            bad_next    = 1'b0;
        end

        if (cmd.leap_div)
        begin
            quot_next = {3'd0, prod100[cda_pkg::DIV100_SHIFT +: 10]};
        end

        if (cmd.leap_set)
        begin
            leap_next = (year_reg[1:0] == 2'd0)
                      && ((rem100 != 16'd0) || (quot_reg[1:0] == 2'd0));
        end

        if (cmd.check)
        begin
            bad_next = !date_ok;
        end

        // Advance one month, or finish inside the current one
        if (cmd.walk)
        begin
            if (fits)
            begin
                day_next = day_reg + rem_reg[4:0];
                rem_next = '0;
            end
            else
            begin
                rem_next = rem_reg - ({{(cda_pkg::REM_W-5){1'b0}}, left}
                                      + {{(cda_pkg::REM_W-1){1'b0}}, 1'b1});
                day_next = 5'd1;
                if (mon_reg == 4'd12)
                begin
                    mon_next  = 4'd1;
                    year_next = year_reg + 16'd1;
                    if (year_reg == 16'hFFFF)
                    begin
                        ovf_next = 1'b1;
                    end
                end
                else
                begin
                    mon_next = mon_reg + 4'd1;
                end
            end
        end

        if (cmd.mon_div)
        begin
            quot_next = prod12[cda_pkg::DIV12_SHIFT +: cda_pkg::SCRATCH_W];
        end

        if (cmd.mon_set)
        begin
            if (op_reg == cda_pkg::OP_ADD_MONTHS)
            begin
                mon_next = rem12[3:0] + 4'd1;
            end
            year_next = ysum[15:0];
            ovf_next  = ysum[cda_pkg::YSUM_W-1:16] != '0;
        end

        if (cmd.clamp)
        begin
            day_next = (anchor_reg < cur_len) ? anchor_reg : cur_len;
        end

        // Hand the finished word to the output register
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
            end_day_next   = day_reg;
            end_month_next = mon_reg;
            end_year_next  = year_reg;
            end_ovf_next   = ovf_reg && !bad_reg;
            end_bad_next   = bad_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        day_reg       <= day_next;
        mon_reg       <= mon_next;
        year_reg      <= year_next;
        rem_reg       <= rem_next;
        anchor_reg    <= anchor_next;
        ovf_reg       <= ovf_next;
        bad_reg       <= bad_next;
        quot_reg      <= quot_next;
        leap_reg      <= leap_next;
        end_day_reg   <= end_day_next;
        end_month_reg <= end_month_next;
        end_year_reg  <= end_year_next;
        end_ovf_reg   <= end_ovf_next;
        end_bad_reg   <= end_bad_next;
    end

    // Output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign end_day       = end_day_reg;
    assign end_month     = end_month_reg;
    assign end_year      = end_year_reg;
    assign year_overflow = end_ovf_reg;
    assign bad_input     = end_bad_reg;

endmodule

// ===== sv/cda_ctrl.sv =====
// Controller of the calendar date adder: sequences leap tests, the month
// walk and the month and year arithmetic through datapath commands.
// Depends on cda_pkg.
module cda_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  cda_pkg::status_t    status,
    output cda_pkg::cmd_t       cmd
);

    cda_pkg::state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cda_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;

        unique case (state_reg)
            cda_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = cda_pkg::ST_LDIV;
                end
            end
            cda_pkg::ST_LDIV:
            begin
                cmd.leap_div = 1'b1;
                state_next   = cda_pkg::ST_LSET;
            end
            cda_pkg::ST_LSET:
            begin
                cmd.leap_set = 1'b1;
                state_next   = cda_pkg::ST_CHECK;
            end
            // Reject bad requests, else pick the walk or the arithmetic path
            cda_pkg::ST_CHECK:
            begin
                cmd.check = 1'b1;
                if (!status.date_ok)
                begin
                    state_next = cda_pkg::ST_OUT;
                end
                else if (status.op_walk)
                begin
                    state_next = cda_pkg::ST_WALK;
                end
                else if (status.op_month)
                begin
                    state_next = cda_pkg::ST_MDIV;
                end
                else
                begin
                    state_next = cda_pkg::ST_MSET;
                end
            end
            cda_pkg::ST_WALK:
            begin
                cmd.walk = 1'b1;
                if (status.walk_last)
                begin
                    state_next = cda_pkg::ST_OUT;
                end
                else if (status.walk_wrap)
                begin
                    state_next = cda_pkg::ST_WDIV;
                end
            end
            // Refresh the leap flag after the walk enters a new year
            cda_pkg::ST_WDIV:
            begin
                cmd.leap_div = 1'b1;
                state_next   = cda_pkg::ST_WSET;
            end
            cda_pkg::ST_WSET:
            begin
                cmd.leap_set = 1'b1;
                state_next   = cda_pkg::ST_WALK;
            end
            cda_pkg::ST_MDIV:
            begin
                cmd.mon_div = 1'b1;
                state_next  = cda_pkg::ST_MSET;
            end
            cda_pkg::ST_MSET:
            begin
                cmd.mon_set = 1'b1;
                state_next  = cda_pkg::ST_CDIV;
            end
            cda_pkg::ST_CDIV:
            begin
                cmd.leap_div = 1'b1;
                state_next   = cda_pkg::ST_CSET;
            end
            cda_pkg::ST_CSET:
            begin
                cmd.leap_set = 1'b1;
                state_next   = cda_pkg::ST_CLAMP;
            end
            cda_pkg::ST_CLAMP:
            begin
                cmd.clamp  = 1'b1;
                state_next = cda_pkg::ST_OUT;
            end
            // Hold until the output register can take the word
            cda_pkg::ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = cda_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cda_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/calendar_date_adder.sv =====
// Calendar date adder top level. Every request first gets a leap test and a
// validity check; a rejected one then goes to the output. Month, year and decade
// additions run the month divide (months only), the year update, a new leap test
// and the day clamp; day and week additions walk one month per cycle, pausing for
// a leap test at each year crossed. One word is in progress at a time: a new one
// is taken only after the last has moved into the output register, which waits
// while that register is full. Reset clears the controller and output valid.
module calendar_date_adder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  op,
    input  logic [4:0]  start_day,
    input  logic [3:0]  start_month,
    input  logic [15:0] start_year,
    input  logic [15:0] step_count,
    input  logic [4:0]  anchor_day,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [4:0]  end_day,
    output logic [3:0]  end_month,
    output logic [15:0] end_year,
    output logic        year_overflow,
    output logic        bad_input
);

    cda_pkg::cmd_t    cmd;
    cda_pkg::status_t status;

    // Sequence the work
    cda_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Hold the date and do the arithmetic
    cda_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .op            (op),
        .start_day     (start_day),
        .start_month   (start_month),
        .start_year    (start_year),
        .step_count    (step_count),
        .anchor_day    (anchor_day),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .end_day       (end_day),
        .end_month     (end_month),
        .end_year      (end_year),
        .year_overflow (year_overflow),
        .bad_input     (bad_input)
    );

endmodule
